// ----- sv/asl_pkg.sv -----
// ----------------------------------------------------------------------------
// asl_pkg
// types and constants shared by the adaptive subset replacement block
// ----------------------------------------------------------------------------
`default_nettype none
package asl_pkg;
  localparam int DEF_SETS          = 1024;
  localparam int DEF_WAYS          = 16;
  localparam int DEF_NUM_GROUPS    = 4;
  localparam int DEF_SMOOTH_LIMIT  = 32;
  localparam int DEF_SAMPLE_BLOCKS = 32;
  localparam int DEF_COUNTER_BITS  = 16;

  localparam int GROUPS       = 8;
  localparam int THR_W        = 8;
  localparam int SET_MISS_W   = 9;
  localparam int CFG_IDX_W    = 3;

  typedef struct packed {
    logic [9:0] set_index;
    logic       is_hit;
    logic [3:0] hit_way;
  } in_item_t;

  typedef struct packed {
    logic [3:0] victim_way;
    logic       victim_valid;
  } out_item_t;
endpackage
`default_nettype wire

// ----- sv/adaptive_subset_lru_replacement.sv -----
// ----------------------------------------------------------------------------
// adaptive_subset_lru_replacement
// true-lru stacks with victim selection from a rotating active subset of ways
// ----------------------------------------------------------------------------
// channel | ports                          | handshake
// in      | start, busy, in_item           | start & !busy
// out     | out_strobe, out_item           | one cycle strobe, no stall
// cfg     | cfg_valid, cfg_ready, cfg_*    | valid & ready
//
// after reset a clearing pass walks all SETS*WAYS stack entries and the
// per-set state, one entry a cycle, busy meanwhile
// a miss keeps busy high through one read of the set state, a sweep over
// all ways (one stack read a cycle, each compared in the cycle after) and a
// finish step; a hit on a valid way sweeps twice, first to find the hit way's
// position, then to rewrite the stack; a hit on an out of range way sweeps
// once; the result strobes for one cycle as busy falls
// the receiver cannot stall, so no output buffering is needed
// ----------------------------------------------------------------------------
`default_nettype none
module adaptive_subset_lru_replacement #(
  parameter int SETS          = asl_pkg::DEF_SETS,
  parameter int WAYS          = asl_pkg::DEF_WAYS,
  parameter int NUM_GROUPS    = asl_pkg::DEF_NUM_GROUPS,
  parameter int SMOOTH_LIMIT  = asl_pkg::DEF_SMOOTH_LIMIT,
  parameter int SAMPLE_BLOCKS = asl_pkg::DEF_SAMPLE_BLOCKS,
  parameter int COUNTER_BITS  = asl_pkg::DEF_COUNTER_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire asl_pkg::in_item_t             in_item,
  output logic                               out_strobe,
  output asl_pkg::out_item_t                 out_item,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [asl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [asl_pkg::THR_W-1:0]     cfg_data
);
  localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W   = $clog2(WAYS);
  localparam int POS_W   = WAY_W;
  localparam int WCNT_W  = WAY_W + 1;
  localparam int SUB_W   = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int SUBSIZE = WAYS / NUM_GROUPS;
  localparam int REG_RAW = SETS / (SAMPLE_BLOCKS * asl_pkg::GROUPS);
  localparam int REGION  = (REG_RAW > 0) ? REG_RAW : 1;
  localparam int SPAN    = REGION * asl_pkg::GROUPS;
  localparam int CLR_W   = SET_W + WAY_W;
  localparam int AGR_W   = 6;
  localparam int GRP_W   = 4;
  localparam logic [COUNTER_BITS-1:0] GMAX = '1;
  localparam logic [asl_pkg::SET_MISS_W-1:0] SMAX = '1;

  // sequencer codes
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RDSET = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  // memories
  logic [POS_W-1:0]                lru_mem [SETS*WAYS];
  logic [SUB_W-1:0]                sub_mem [SETS];
  logic [asl_pkg::SET_MISS_W-1:0]  cnt_mem [SETS];

  logic [2:0]                      state_r;
  logic [CLR_W-1:0]                clr_r;
  logic [SET_W-1:0]                set_r;
  logic                            hit_r;
  logic [3:0]                      hway_r;
  logic                            hway_ok_r;
  logic [WCNT_W-1:0]               rw_r;      // way being read
  logic [POS_W-1:0]                rd_q_r;    // registered read data
  logic                            rd_v_r;
  logic [WAY_W-1:0]                rd_w_r;
  logic [POS_W-1:0]                cur_r;     // stack position of hit way
  logic                            cur_ok_r;
  logic [SUB_W-1:0]                sub_r;
  logic [asl_pkg::SET_MISS_W-1:0]  scnt_r;
  logic [WAY_W-1:0]                best_r;
  logic [POS_W-1:0]                bestp_r;
  logic                            bestv_r;
  logic [asl_pkg::THR_W-1:0]       thr_r [asl_pkg::GROUPS];
  logic [COUNTER_BITS-1:0]         gcnt_r [asl_pkg::GROUPS];
  logic [GRP_W-1:0]                last_r;
  logic [AGR_W-1:0]                agr_r;
  logic                            ostb_r;
  asl_pkg::out_item_t              oitem_r;
  // threshold chosen for this miss (group bookkeeping done at end of sweep)
  logic [asl_pkg::THR_W-1:0]       thr_sel_r;

  logic [SET_W-1:0] in_set;
  assign in_set = SET_W'({22'd0, in_item.set_index} % SETS);

  // sample group of the set in flight, 0 for follower sets
  logic [GRP_W-1:0] grp;
  always_comb begin
    int unsigned s;
    s = 32'(set_r);
    grp = '0;
    if ((s / SPAN) < SAMPLE_BLOCKS && ((s % SPAN) % REGION) == 0)
      grp = GRP_W'((s % SPAN) / REGION + 1);
  end

  // lowest group counter, ties to the lower group
  logic [GRP_W-1:0] low;
  always_comb begin
    low = GRP_W'(1);
    for (int g = 2; g <= asl_pkg::GROUPS; g++)
      if (gcnt_r[low-1] > gcnt_r[g-1]) low = GRP_W'(g);
  end

  // subset window of the set in flight
  logic [WCNT_W+SUB_W-1:0] sub_start;
  assign sub_start = (WCNT_W+SUB_W)'(sub_r) * (WCNT_W+SUB_W)'(SUBSIZE);

  logic in_win;
  assign in_win = ((WCNT_W+SUB_W)'(rd_w_r) >= sub_start) &&
                  ((WCNT_W+SUB_W)'(rd_w_r) < sub_start + (WCNT_W+SUB_W)'(SUBSIZE));

  logic [CLR_W-1:0] rd_addr, wr_addr;
  assign rd_addr = {set_r, rw_r[WAY_W-1:0]};
  assign wr_addr = {set_r, rd_w_r};

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_strobe = ostb_r;
  assign out_item   = oitem_r;

  // memory ports
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      lru_mem[clr_r] <= POS_W'(clr_r[WAY_W-1:0]);
      sub_mem[clr_r[CLR_W-1:WAY_W]] <= '0;
      cnt_mem[clr_r[CLR_W-1:WAY_W]] <= '0;
    end else begin
      if (state_r == ST_SWEEP && rd_v_r && hit_r && cur_ok_r && hway_ok_r) begin
        if (rd_w_r == hway_r[WAY_W-1:0]) lru_mem[wr_addr] <= '0;
        else if (rd_q_r < cur_r) lru_mem[wr_addr] <= rd_q_r + POS_W'(1);
      end
      if (state_r == ST_FIN && !hit_r) begin
        if (scnt_r != SMAX) begin
          if (scnt_r + 1'b1 > {1'b0, thr_sel_r}) begin
            cnt_mem[set_r] <= '0;
            sub_mem[set_r] <= (32'(sub_r) + 1 >= NUM_GROUPS) ? '0 : sub_r + 1'b1;
          end else cnt_mem[set_r] <= scnt_r + 1'b1;
        end else if (scnt_r > {1'b0, thr_sel_r}) begin
          cnt_mem[set_r] <= '0;
          sub_mem[set_r] <= (32'(sub_r) + 1 >= NUM_GROUPS) ? '0 : sub_r + 1'b1;
        end
      end
    end
    rd_q_r <= lru_mem[rd_addr];
    sub_r  <= (state_r == ST_RDSET) ? sub_mem[set_r] : sub_r;
    scnt_r <= (state_r == ST_RDSET) ? cnt_mem[set_r] : scnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      ostb_r  <= 1'b0;
      last_r  <= '0;
      agr_r   <= '0;
      for (int g = 0; g < asl_pkg::GROUPS; g++) begin
        thr_r[g]  <= asl_pkg::THR_W'(16);
        gcnt_r[g] <= '0;
      end
    end else begin
      ostb_r <= 1'b0;
      if (cfg_valid) thr_r[cfg_index] <= cfg_data;
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (32'(clr_r) == SETS*WAYS-1) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (start) begin
            set_r     <= in_set;
            hit_r     <= in_item.is_hit;
            hway_r    <= in_item.hit_way;
            hway_ok_r <= (32'(in_item.hit_way) < WAYS);
            state_r   <= ST_RDSET;
          end
        end
        ST_RDSET: begin
          rw_r <= '0;
          rd_v_r <= 1'b0;
          cur_ok_r <= 1'b0;
          bestv_r <= 1'b0;
          best_r <= '0;
          bestp_r <= '0;
          state_r <= ST_SWEEP;
          // on a hit the first pass over ways only finds the hit way's position
        end
        ST_SWEEP: begin
          // two passes on a hit to a valid way: locate current position, then update
          if (rd_v_r) begin
            if (!hit_r && in_win && (!bestv_r || rd_q_r > bestp_r)) begin
              best_r <= rd_w_r; bestp_r <= rd_q_r; bestv_r <= 1'b1;
            end
            if (hit_r && !cur_ok_r && rd_w_r == hway_r[WAY_W-1:0]) begin
              cur_r <= rd_q_r;
            end
          end
          rd_w_r <= rw_r[WAY_W-1:0];
          if (32'(rw_r) < WAYS) begin
            rd_v_r <= 1'b1;
            rw_r <= rw_r + 1'b1;
          end else begin
            rd_v_r <= 1'b0;
            if (hit_r && !cur_ok_r && hway_ok_r) begin
              cur_ok_r <= 1'b1;
              rw_r <= '0;
            end else begin
              state_r <= ST_FIN;
              if (!hit_r) begin
                if (grp != '0) begin
                  if (gcnt_r[grp-1] != GMAX) gcnt_r[grp-1] <= gcnt_r[grp-1] + 1'b1;
                  thr_sel_r <= thr_r[grp-1];
                end else begin
                  thr_sel_r <= thr_r[low-1];
                  if (low == last_r) begin
                    if (32'(agr_r) + 1 > SMOOTH_LIMIT) begin
                      agr_r <= '0;
                      for (int g = 0; g < asl_pkg::GROUPS; g++) gcnt_r[g] <= '0;
                    end else agr_r <= agr_r + 1'b1;
                  end else begin
                    if (agr_r != '0) agr_r <= agr_r - 1'b1;
                    last_r <= low;
                  end
                end
              end
            end
          end
        end
        ST_FIN: begin
          ostb_r <= 1'b1;
          oitem_r.victim_valid <= !hit_r;
          oitem_r.victim_way <= (hit_r || SUBSIZE == 0) ? 4'd0 : 4'(best_r);
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // no transaction accepted while the clearing pass runs
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> busy) else $error("accepted during clear");
  // a result only follows the finish step
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r) == ST_FIN) else $error("stray result");
  // a hit never reports a victim
  a_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.victim_valid |-> out_item.victim_way == 4'd0)
    else $error("victim on hit");
endmodule
`default_nettype wire
